[rtl/fcct_pkg.sv]
// ----------------------------------------------------------------------------
// fcct_pkg: shared types and codes of the cluster chain table
// Request kinds, status codes, configuration indexes and the result record
// that the sequencer hands to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package fcct_pkg;

  // Field widths of the item and of the configuration registers
  localparam int CLU_W = 12;
  localparam int VAL_W = 28;
  localparam int SEC_W = 25;
  localparam int TE_W  = 13;
  localparam int SS_W  = 12;
  localparam int DS_W  = 24;

  // Configuration register indexes
  localparam logic [1:0] CFG_TABLE_ENTRIES = 2'd0;
  localparam logic [1:0] CFG_SEARCH_START  = 2'd1;
  localparam logic [1:0] CFG_SECTOR_BASE   = 2'd2;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PUT    = 2'd2,
    REQ_GET    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BROKEN = 2'd2
  } status_t;

  typedef struct packed {
    logic [TE_W-1:0] table_entries;
    logic [SS_W-1:0] search_start;
    logic [DS_W-1:0] sector_base;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [SEC_W-1:0] sector;
    logic [VAL_W-1:0] read_value;
    logic [CLU_W-1:0] result_cluster;
  } res_t;

endpackage

`default_nettype wire

[rtl/fcct_link_ram.sv]
// ----------------------------------------------------------------------------
// fcct_link_ram: link table storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fcct_link_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 28
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, data valid on the next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/fcct_engine.sv]
// ----------------------------------------------------------------------------
// fcct_engine: request sequencer of the cluster chain table
// Clears the table after reset, then runs the free search, splice, chain
// walk, put and get through the table's write and read ports, one entry per step.
// ----------------------------------------------------------------------------
`default_nettype none

module fcct_engine #(
  parameter int TABLE_DEPTH = 4096,
  parameter int ENTRY_BITS  = 28
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire fcct_pkg::cfg_t                     cfg,
  input  wire logic                               start,
  input  wire fcct_pkg::req_t                     req,
  input  wire logic [fcct_pkg::CLU_W-1:0]         clu,
  input  wire logic [fcct_pkg::CLU_W-1:0]         prev,
  input  wire logic [fcct_pkg::VAL_W-1:0]         val,
  output logic                                    idle,
  output logic                                    done,
  output fcct_pkg::res_t                          res,
  input  wire logic                               res_ack,
  output logic                                    ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]          ram_waddr,
  output logic [ENTRY_BITS-1:0]                   ram_wdata,
  output logic                                    ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0]          ram_raddr,
  input  wire logic [ENTRY_BITS-1:0]              ram_rdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = (IW + 1 > fcct_pkg::TE_W) ? IW + 1 : fcct_pkg::TE_W;
  localparam logic [32:0]           DEPTH_L = 33'(TABLE_DEPTH);
  localparam logic [IW-1:0]         LAST_IX = IW'(TABLE_DEPTH - 1);
  localparam logic [ENTRY_BITS-1:0] END_MARK = {ENTRY_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_CR_RD, S_CR_LINK, S_CR_TAIL,
    S_RM_PREV, S_RM_RD, S_RM_CHK, S_PUT_WR, S_GET_RD, S_GET_WAIT, S_DONE
  } state_t;

  state_t                      state_r;
  logic [IW-1:0]               clr_r;
  logic [fcct_pkg::CLU_W-1:0]  clu_r;
  logic [fcct_pkg::CLU_W-1:0]  prev_r;
  logic [fcct_pkg::VAL_W-1:0]  val_r;
  logic [CW-1:0]               idx_r;
  logic [CW-1:0]               steps_r;
  logic [ENTRY_BITS-1:0]       cur_r;
  logic [ENTRY_BITS-1:0]       old_r;
  fcct_pkg::res_t              res_r;

  logic [CW-1:0]               len;
  logic                        clu_ok;
  logic                        prev_ok;
  logic                        walk_ok;
  logic                        srch_end;
  logic [fcct_pkg::SEC_W-1:0]  sec_clu;
  logic [fcct_pkg::SEC_W-1:0]  sec_idx;

  // Effective table length and range checks
  assign len      = (33'(cfg.table_entries) > DEPTH_L) ? CW'(TABLE_DEPTH)
                                                       : CW'(cfg.table_entries);
  assign clu_ok   = 33'(clu_r) < DEPTH_L;
  assign prev_ok  = (prev_r != '0) && (33'(prev_r) < DEPTH_L);
  assign walk_ok  = (steps_r < len) && (33'(cur_r) < DEPTH_L);
  assign srch_end = idx_r >= len;
  assign sec_clu  = fcct_pkg::SEC_W'(cfg.sector_base) + fcct_pkg::SEC_W'(clu_r);
  assign sec_idx  = fcct_pkg::SEC_W'(cfg.sector_base) + fcct_pkg::SEC_W'(idx_r);

  assign idle = state_r == S_IDLE;
  assign done = state_r == S_DONE;
  assign res  = res_r;

  // Drive the table port for the current step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[IW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_r[IW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      S_SRCH_RD: begin
        ram_re = !srch_end;
      end
      S_CR_RD: begin
        ram_re    = clu_ok;
        ram_raddr = IW'(clu_r);
      end
      S_CR_LINK: begin
        ram_we    = clu_ok;
        ram_waddr = IW'(clu_r);
        ram_wdata = ENTRY_BITS'(idx_r);
      end
      S_CR_TAIL: begin
        ram_we    = 1'b1;
        ram_wdata = (old_r == '0) ? END_MARK : old_r;
      end
      S_RM_PREV: begin
        ram_we    = prev_ok;
        ram_waddr = IW'(prev_r);
        ram_wdata = END_MARK;
      end
      S_RM_RD: begin
        ram_re    = walk_ok;
        ram_raddr = IW'(cur_r);
      end
      S_RM_CHK: begin
        ram_we    = ram_rdata != '0;
        ram_waddr = IW'(cur_r);
      end
      S_PUT_WR: begin
        ram_we    = clu_ok;
        ram_waddr = IW'(clu_r);
        ram_wdata = ENTRY_BITS'(val_r);
      end
      S_GET_RD: begin
        ram_re    = clu_ok;
        ram_raddr = IW'(clu_r);
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and result record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      unique case (state_r)
        // Sweep zeros through the table, one entry a cycle
        S_CLEAR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == LAST_IX) begin
            state_r <= S_IDLE;
          end
        end
        // Latch the item and dispatch on its kind
        S_IDLE: begin
          if (start) begin
            clu_r   <= clu;
            prev_r  <= prev;
            val_r   <= val;
            idx_r   <= (cfg.search_start == '0) ? CW'(1) : CW'(cfg.search_start);
            steps_r <= '0;
            cur_r   <= ENTRY_BITS'(clu);
            old_r   <= '0;
            unique case (req)
              fcct_pkg::REQ_CREATE: state_r <= S_SRCH_RD;
              fcct_pkg::REQ_REMOVE: state_r <= S_RM_PREV;
              fcct_pkg::REQ_PUT:    state_r <= S_PUT_WR;
              fcct_pkg::REQ_GET:    state_r <= S_GET_RD;
              default:              state_r <= S_IDLE;
            endcase
          end
        end
        // Free search: stop at the length, else read the next entry
        S_SRCH_RD: begin
          if (srch_end) begin
            res_r.result_cluster <= '0;
            res_r.read_value     <= '0;
            res_r.sector         <= fcct_pkg::SEC_W'(cfg.sector_base);
            res_r.status         <= fcct_pkg::ST_FULL;
            state_r              <= S_DONE;
          end else begin
            state_r <= S_SRCH_CHK;
          end
        end
        S_SRCH_CHK: begin
          if (ram_rdata == '0) begin
            res_r.result_cluster <= fcct_pkg::CLU_W'(idx_r);
            res_r.read_value     <= '0;
            res_r.sector         <= sec_idx;
            res_r.status         <= fcct_pkg::ST_OK;
            state_r              <= (clu_r == '0) ? S_CR_TAIL : S_CR_RD;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_SRCH_RD;
          end
        end
        // Splice: fetch the old link, point the cluster at the new entry, then write the new entry's link
        S_CR_RD: begin
          state_r <= S_CR_LINK;
        end
        S_CR_LINK: begin
          old_r   <= clu_ok ? ram_rdata : '0;
          state_r <= S_CR_TAIL;
        end
        S_CR_TAIL: begin
          state_r <= S_DONE;
        end
        // Remove: end the previous cluster, then walk and free the chain
        S_RM_PREV: begin
          res_r.result_cluster <= '0;
          res_r.read_value     <= '0;
          res_r.sector         <= sec_clu;
          res_r.status         <= fcct_pkg::ST_BROKEN;
          state_r              <= S_RM_RD;
        end
        S_RM_RD: begin
          state_r <= walk_ok ? S_RM_CHK : S_DONE;
        end
        S_RM_CHK: begin
          if (ram_rdata == '0) begin
            state_r <= S_DONE;
          end else if (ram_rdata == END_MARK) begin
            res_r.status <= fcct_pkg::ST_OK;
            state_r      <= S_DONE;
          end else begin
            cur_r   <= ram_rdata;
            steps_r <= steps_r + CW'(1);
            state_r <= S_RM_RD;
          end
        end
        // Put: single write
        S_PUT_WR: begin
          res_r.result_cluster <= '0;
          res_r.read_value     <= '0;
          res_r.sector         <= sec_clu;
          res_r.status         <= fcct_pkg::ST_OK;
          state_r              <= S_DONE;
        end
        // Get: single read, zero when out of range
        S_GET_RD: begin
          state_r <= S_GET_WAIT;
        end
        S_GET_WAIT: begin
          res_r.result_cluster <= '0;
          res_r.read_value     <= clu_ok ? fcct_pkg::VAL_W'(ram_rdata) : '0;
          res_r.sector         <= sec_clu;
          res_r.status         <= fcct_pkg::ST_OK;
          state_r              <= S_DONE;
        end
        // Hold the result until the output stage takes it
        S_DONE: begin
          if (res_ack) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/fat_cluster_chain_table.sv]
// ----------------------------------------------------------------------------
// fat_cluster_chain_table: FAT style cluster chain table
// Link table with free-entry allocation, chain removal, put and get.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream (kind in in_tuser), one result per
//   request leaves on the out_ stream. Configuration is written through
//   cfg_we / cfg_index / cfg_wdata while no request is in flight.
//   The block handles one request at a time through the table's write
//   and read ports. Create runs the free search entry by entry, remove
//   walks the chain entry by entry; the next request is taken in the
//   cycle after a result enters the register. After reset the table is
//   cleared, one entry a cycle; in_tready stays low meanwhile, and
//   configuration writes are taken. The result sits in an output
//   register: a new request is accepted while it waits, and a finished
//   result waits inside until out_tready frees it.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_cluster_chain_table #(
  parameter int TABLE_DEPTH = 4096,
  parameter int ENTRY_BITS  = 28
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata,
  // Request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // cluster[11:0], prev_cluster[23:12], value[51:24]
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // result_cluster[11:0], read_value[39:12],
                                       // sector[64:40], status[66:65]
);

  localparam int IW = $clog2(TABLE_DEPTH);

  fcct_pkg::cfg_t        cfg_r;
  fcct_pkg::res_t        eng_res;
  fcct_pkg::res_t        out_res_r;
  logic                  out_valid_r;
  logic                  eng_idle;
  logic                  eng_done;
  logic                  eng_ack;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [IW-1:0]         ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.table_entries <= fcct_pkg::TE_W'(4096);
      cfg_r.search_start  <= fcct_pkg::SS_W'(1);
      cfg_r.sector_base   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fcct_pkg::CFG_TABLE_ENTRIES: cfg_r.table_entries <= cfg_wdata[fcct_pkg::TE_W-1:0];
        fcct_pkg::CFG_SEARCH_START:  cfg_r.search_start  <= cfg_wdata[fcct_pkg::SS_W-1:0];
        fcct_pkg::CFG_SECTOR_BASE:   cfg_r.sector_base   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_tready = eng_idle;
  assign eng_ack   = eng_done && (!out_valid_r || out_tready);

  fcct_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_tvalid && eng_idle),
    .req       (fcct_pkg::req_t'(in_tuser)),
    .clu       (in_tdata[11:0]),
    .prev      (in_tdata[23:12]),
    .val       (in_tdata[51:24]),
    .idle      (eng_idle),
    .done      (eng_done),
    .res       (eng_res),
    .res_ack   (eng_ack),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  fcct_link_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: load a finished result, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (eng_ack) begin
        out_valid_r <= 1'b1;
        out_res_r   <= eng_res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.status, out_res_r.sector,
                       out_res_r.read_value, out_res_r.result_cluster};

endmodule

`default_nettype wire

[rtl/fcct_checker.sv]
// ----------------------------------------------------------------------------
// fcct_checker: port-level checks of the cluster chain table
// Watches both streams and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcct_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);

  // One request at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an accepted item");

  // Status code is never the unused value
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[66:65] <= 2'(fcct_pkg::ST_BROKEN))
    else $error("unused status code on result");

  // A full table reports no allocated cluster
  a_full_no_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66:65] == 2'(fcct_pkg::ST_FULL) |-> out_tdata[11:0] == 12'd0)
    else $error("table full result with nonzero cluster");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind fat_cluster_chain_table fcct_checker u_fcct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[bench/fat_cluster_chain_table_tb.sv]
// ----------------------------------------------------------------------------
// fat_cluster_chain_table_tb: self-checking bench of the cluster chain table
// Drives create, remove, put and get requests on the request stream, tracks
// the link table and the registers in a scoreboard, and compares every
// result item field by field. A directed opening covers chain splicing, full
// table, broken walks and walk bounds; random phases sweep the registers.
// ----------------------------------------------------------------------------
module fat_cluster_chain_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 4096;
  localparam int ENTRY_BITS  = 28;
  localparam logic [fcct_pkg::VAL_W-1:0] END_MARK = '1;

  // Scoreboard: shadow link table, register copies, results still awaited
  class cluster_chain_tracker;
    logic [fcct_pkg::VAL_W-1:0] links [TABLE_DEPTH];
    logic [fcct_pkg::TE_W-1:0]  table_entries;
    logic [fcct_pkg::SS_W-1:0]  search_start;
    logic [fcct_pkg::DS_W-1:0]  sector_base;
    fcct_pkg::res_t             awaited [$];
    int                         mismatches;

    function new();
      foreach (links[i]) links[i] = '0;
      table_entries = 13'd4096;
      search_start  = 12'd1;
      sector_base   = '0;
      mismatches    = 0;
    endfunction

    function int unsigned span();
      return (table_entries > TABLE_DEPTH) ? TABLE_DEPTH : table_entries;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        fcct_pkg::CFG_TABLE_ENTRIES: table_entries = data[fcct_pkg::TE_W-1:0];
        fcct_pkg::CFG_SEARCH_START:  search_start  = data[fcct_pkg::SS_W-1:0];
        fcct_pkg::CFG_SECTOR_BASE:   sector_base   = data[fcct_pkg::DS_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request to the shadow table and queue its result
    function void note_request(fcct_pkg::req_t req, logic [fcct_pkg::CLU_W-1:0] clu,
                               logic [fcct_pkg::CLU_W-1:0] prev,
                               logic [fcct_pkg::VAL_W-1:0] val);
      fcct_pkg::res_t             r;
      int unsigned                len;
      int unsigned                idx;
      int unsigned                steps;
      bit                         found;
      logic [fcct_pkg::VAL_W-1:0] old_link;
      logic [fcct_pkg::VAL_W-1:0] nxt;
      logic [fcct_pkg::VAL_W-1:0] cur;
      len = span();
      r = '0;
      r.status = fcct_pkg::ST_OK;
      r.sector = {1'b0, sector_base} + clu;
      case (req)
        fcct_pkg::REQ_CREATE: begin
          // Lowest free entry from the search start; cluster zero is never used
          idx = (search_start == 0) ? 1 : search_start;
          found = 1'b0;
          while (idx < len && !found) begin
            if (links[idx] == '0) found = 1'b1;
            else idx++;
          end
          if (!found) begin
            r.status = fcct_pkg::ST_FULL;
            r.sector = {1'b0, sector_base};
          end else begin
            if (clu == 0) begin
              links[idx] = END_MARK;
            end else begin
              // Splice after clu; a free clu makes the new entry a chain end
              old_link = links[clu];
              links[clu] = fcct_pkg::VAL_W'(idx);
              links[idx] = (old_link == '0) ? END_MARK : old_link;
            end
            r.result_cluster = fcct_pkg::CLU_W'(idx);
            r.sector = {1'b0, sector_base} + fcct_pkg::CLU_W'(idx);
          end
        end
        fcct_pkg::REQ_REMOVE: begin
          if (prev != 0) links[prev] = END_MARK;
          r.status = fcct_pkg::ST_BROKEN;
          cur = fcct_pkg::VAL_W'(clu);
          for (steps = 0; steps < len; steps++) begin
            if (cur >= TABLE_DEPTH) break;
            nxt = links[cur[fcct_pkg::CLU_W-1:0]];
            if (nxt == '0) break;
            links[cur[fcct_pkg::CLU_W-1:0]] = '0;
            if (nxt == END_MARK) begin
              r.status = fcct_pkg::ST_OK;
              break;
            end
            cur = nxt;
          end
        end
        fcct_pkg::REQ_PUT: links[clu] = val;
        default: r.read_value = links[clu];
      endcase
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Match one result item against the oldest awaited result
    function void check_result(logic [71:0] data);
      fcct_pkg::res_t got;
      fcct_pkg::res_t want;
      got = fcct_pkg::res_t'(data[$bits(fcct_pkg::res_t)-1:0]);
      if (awaited.size() == 0) begin
        $error("result item with no request outstanding: %h", data);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("result_cluster", want.result_cluster, got.result_cluster);
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("sector", want.sector, got.sector);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [23:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;   // cluster[11:0], prev_cluster[23:12], value[51:24]
  logic [1:0]  in_tuser   = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;         // result_cluster[11:0], read_value[39:12],
                                  // sector[64:40], status[66:65]

  cluster_chain_tracker tracker = new();
  bit          idling = 1'b1;
  int          stall_left = 0;
  int unsigned cur_len = TABLE_DEPTH;

  fat_cluster_chain_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ENTRY_BITS (ENTRY_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both streams; note requests before checking results
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      tracker.note_request(fcct_pkg::req_t'(in_tuser), in_tdata[11:0], in_tdata[23:12],
                           in_tdata[51:24]);
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(out_tdata);
  end

  // Hold off the result stream in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(fcct_pkg::req_t req, logic [fcct_pkg::CLU_W-1:0] clu,
                              logic [fcct_pkg::CLU_W-1:0] prev,
                              logic [fcct_pkg::VAL_W-1:0] val);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0, val, prev, clu};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [fcct_pkg::TE_W-1:0] te, logic [fcct_pkg::SS_W-1:0] ss,
                              logic [fcct_pkg::DS_W-1:0] ds);
    cfg_we    <= 1'b1;
    cfg_index <= fcct_pkg::CFG_TABLE_ENTRIES;
    cfg_wdata <= 24'(te);
    @(posedge clk);
    cfg_index <= fcct_pkg::CFG_SEARCH_START;
    cfg_wdata <= 24'(ss);
    @(posedge clk);
    cfg_index <= fcct_pkg::CFG_SECTOR_BASE;
    cfg_wdata <= ds;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(fcct_pkg::CFG_TABLE_ENTRIES, 24'(te));
    tracker.write_reg(fcct_pkg::CFG_SEARCH_START, 24'(ss));
    tracker.write_reg(fcct_pkg::CFG_SECTOR_BASE, ds);
    cur_len = tracker.span();
  endtask

  // Mostly an entry inside the active span, now and then any index
  function automatic logic [fcct_pkg::CLU_W-1:0] pick_cluster();
    if (cur_len == 0 || $urandom_range(0, 5) == 0) return fcct_pkg::CLU_W'($urandom);
    return fcct_pkg::CLU_W'($urandom_range(0, cur_len - 1));
  endfunction

  task automatic random_request();
    int unsigned                roll;
    logic [fcct_pkg::VAL_W-1:0] noise;
    logic [fcct_pkg::VAL_W-1:0] link;
    roll  = $urandom_range(0, 99);
    noise = fcct_pkg::VAL_W'($urandom);
    if (roll < 35) begin
      send_request(fcct_pkg::REQ_CREATE, ($urandom_range(0, 2) == 0) ? '0 : pick_cluster(),
                   fcct_pkg::CLU_W'($urandom), noise);
    end else if (roll < 60) begin
      send_request(fcct_pkg::REQ_REMOVE, pick_cluster(),
                   ($urandom_range(0, 1) == 0) ? '0 : pick_cluster(), noise);
    end else if (roll < 80) begin
      case ($urandom_range(0, 3))
        0:       link = END_MARK;
        1:       link = fcct_pkg::VAL_W'(pick_cluster());
        2:       link = noise;
        default: link = '0;
      endcase
      send_request(fcct_pkg::REQ_PUT, pick_cluster(), fcct_pkg::CLU_W'($urandom), link);
    end else begin
      send_request(fcct_pkg::REQ_GET, pick_cluster(), fcct_pkg::CLU_W'($urandom), noise);
    end
  endtask

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned               n_items;
    logic [fcct_pkg::TE_W-1:0] te;
    logic [fcct_pkg::SS_W-1:0] ss;
    logic [fcct_pkg::DS_W-1:0] ds;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: whole table, search from one, data at sector zero
    send_request(fcct_pkg::REQ_GET, '0, '0, '0);
    send_request(fcct_pkg::REQ_CREATE, '0, 12'hFFF, END_MARK);
    send_request(fcct_pkg::REQ_CREATE, 12'd1, '0, '0);
    send_request(fcct_pkg::REQ_CREATE, 12'd5, '0, '0);
    send_request(fcct_pkg::REQ_GET, 12'd1, '0, '0);
    send_request(fcct_pkg::REQ_GET, 12'd5, '0, '0);
    send_request(fcct_pkg::REQ_PUT, 12'hFFF, '0, END_MARK);
    send_request(fcct_pkg::REQ_GET, 12'hFFF, 12'hFFF, '0);
    send_request(fcct_pkg::REQ_PUT, 12'hFFE, 12'hFFF, 28'h5555555);
    send_request(fcct_pkg::REQ_REMOVE, 12'd1, '0, '0);
    // Free start entry: previous cluster still gets the end marker
    send_request(fcct_pkg::REQ_REMOVE, 12'd7, 12'd5, '0);
    // Link pointing outside the table stops the walk
    send_request(fcct_pkg::REQ_PUT, 12'd10, '0, 28'h0001000);
    send_request(fcct_pkg::REQ_REMOVE, 12'd10, '0, '0);
    send_request(fcct_pkg::REQ_GET, 12'd10, '0, '0);
    send_request(fcct_pkg::REQ_REMOVE, 12'hFFF, '0, '0);

    // Four entries, search start zero: fill up, then overflow
    wait_idle();
    write_config(13'd4, '0, 24'hFFFFFF);
    send_request(fcct_pkg::REQ_CREATE, '0, '0, '0);
    send_request(fcct_pkg::REQ_CREATE, '0, '0, '0);
    send_request(fcct_pkg::REQ_CREATE, '0, '0, '0);
    // Chain longer than the span: walk stops at the bound
    send_request(fcct_pkg::REQ_PUT, 12'd100, '0, 28'd101);
    send_request(fcct_pkg::REQ_PUT, 12'd1, '0, 28'd2);
    send_request(fcct_pkg::REQ_PUT, 12'd2, '0, 28'd3);
    send_request(fcct_pkg::REQ_PUT, 12'd3, '0, 28'd100);
    send_request(fcct_pkg::REQ_REMOVE, 12'd1, '0, '0);
    send_request(fcct_pkg::REQ_GET, 12'd101, '0, '0);

    // Zero span: nothing to allocate, nothing to walk
    wait_idle();
    write_config('0, 12'hFFF, '0);
    send_request(fcct_pkg::REQ_REMOVE, 12'd3, '0, '0);
    send_request(fcct_pkg::REQ_CREATE, '0, '0, '0);

    // Random phases; a couple over the whole table, clamped span among them
    for (int phase = 0; phase < 22; phase++) begin
      wait_idle();
      idling = (phase < 19);
      if (phase == 5)       te = 13'd4096;
      else if (phase == 12) te = 13'h1FFF;
      else if (phase == 9)  te = 13'd1;
      else                  te = fcct_pkg::TE_W'($urandom_range(2, 64));
      case ($urandom_range(0, 7))
        0:       ss = '0;
        1:       ss = 12'hFFF;
        default: ss = fcct_pkg::SS_W'($urandom_range(0, (te > 13'd4096 ? 4096 : te) - 1));
      endcase
      case ($urandom_range(0, 3))
        0:       ds = '0;
        1:       ds = 24'hFFFFFF;
        default: ds = fcct_pkg::DS_W'($urandom);
      endcase
      write_config(te, ss, ds);
      n_items = (phase == 5 || phase == 12) ? 15 : 50;
      repeat (n_items) random_request();
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fcct_pkg.sv
rtl/fcct_link_ram.sv
rtl/fcct_engine.sv
rtl/fat_cluster_chain_table.sv
rtl/fcct_checker.sv
bench/fat_cluster_chain_table_tb.sv
